### src/cosine_similarity_defines.svh
// Assertion macros used by the cosine similarity checker.
`ifndef COSINE_SIMILARITY_DEFINES_SVH
`define COSINE_SIMILARITY_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CS_ASSERT_IMPLY(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define CS_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/cossim_pkg.sv
// Shared widths, limits and types for the cosine similarity block.
package cossim_pkg;

  // Element and product widths
  localparam int ELEM_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_BITS;

  // Running sums and their one-bit-wider pre-saturation forms
  localparam int DOT_W   = 44;
  localparam int NORM_W  = 43;
  localparam int DOT_XW  = DOT_W + 1;
  localparam int NORM_XW = NORM_W + 1;

  localparam logic signed [DOT_W-1:0] DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]        NORM_MAX = {NORM_W{1'b1}};

  // Serial multiplier: operands up to the dot magnitude width
  localparam int MAG_W     = DOT_W;
  localparam int MUL_W     = 2 * MAG_W;
  localparam int MUL_CNT_W = $clog2(MAG_W);

  // Result search: Q1.15 quotient, squared scale of 2^30
  localparam int Q_W     = 16;
  localparam int Q_FRAC  = Q_W - 1;
  localparam int R_SHIFT = 2 * Q_FRAC;
  localparam int SRCH_W  = MUL_W + 2 * Q_W;
  localparam int BIT_W   = $clog2(Q_W);
  localparam int SH_W    = BIT_W + 1;

  localparam logic [Q_W-1:0] SIM_MAX = {1'b0, {(Q_W-1){1'b1}}};

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Finished sums of one vector pair
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
    logic                    sat;
  } sums_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_TEST,
    ST_OUT
  } back_state_t;

endpackage

### src/cossim_accum.sv
// Front end: takes element pairs, squares and multiplies, keeps saturating sums.
module cossim_accum (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic signed [cossim_pkg::ELEM_BITS-1:0]   element_a,
  input  logic signed [cossim_pkg::ELEM_BITS-1:0]   element_b,
  input  logic                                      last_element,
  input  logic                                      elem_valid,
  output logic                                      elem_stall,
  output logic                                      push,
  output cossim_pkg::sums_t                         push_data,
  input  cossim_pkg::fifo_stat_t                    fifo_stat
);

  logic                                   accept;
  logic                                   advance;
  logic                                   s1_valid;
  logic                                   s1_last;
  logic signed [cossim_pkg::PROD_W-1:0]   prod_ab;
  logic [cossim_pkg::PROD_W-1:0]          prod_aa;
  logic [cossim_pkg::PROD_W-1:0]          prod_bb;
  logic signed [cossim_pkg::PROD_W-1:0]   sq_a;
  logic signed [cossim_pkg::PROD_W-1:0]   sq_b;
  logic signed [cossim_pkg::PROD_W-1:0]   mul_ab;

  logic signed [cossim_pkg::DOT_W-1:0]    dot_sum;
  logic [cossim_pkg::NORM_W-1:0]          norm_a_sum;
  logic [cossim_pkg::NORM_W-1:0]          norm_b_sum;
  logic                                   saturated_flag;

  logic signed [cossim_pkg::DOT_XW-1:0]   dot_wide;
  logic [cossim_pkg::NORM_XW-1:0]         na_wide;
  logic [cossim_pkg::NORM_XW-1:0]         nb_wide;
  logic                                   dot_of;
  logic                                   na_of;
  logic                                   nb_of;
  logic signed [cossim_pkg::DOT_W-1:0]    dot_next;
  logic [cossim_pkg::NORM_W-1:0]          norm_a_next;
  logic [cossim_pkg::NORM_W-1:0]          norm_b_next;
  logic                                   sat_next;

  // Hold the input only while a last pair waits for queue space
  assign advance    = s1_valid & (~s1_last | ~fifo_stat.full);
  assign elem_stall = s1_valid & s1_last & fifo_stat.full;
  assign accept     = elem_valid & ~elem_stall;

  // Form the three products
  assign mul_ab = element_a * element_b;
  assign sq_a   = element_a * element_a;
  assign sq_b   = element_b * element_b;

  // Product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= last_element;
      prod_ab <= mul_ab;
      prod_aa <= $unsigned(sq_a);
      prod_bb <= $unsigned(sq_b);
    end
  end

  // Add products into the sums and saturate at the sum widths
  always_comb begin
    dot_wide = cossim_pkg::DOT_XW'(dot_sum) + cossim_pkg::DOT_XW'(prod_ab);
    na_wide  = cossim_pkg::NORM_XW'(norm_a_sum) + cossim_pkg::NORM_XW'(prod_aa);
    nb_wide  = cossim_pkg::NORM_XW'(norm_b_sum) + cossim_pkg::NORM_XW'(prod_bb);
    dot_of   = dot_wide[cossim_pkg::DOT_W] != dot_wide[cossim_pkg::DOT_W-1];
    na_of    = na_wide[cossim_pkg::NORM_W];
    nb_of    = nb_wide[cossim_pkg::NORM_W];
    if (dot_of) begin
      dot_next = dot_wide[cossim_pkg::DOT_W] ? cossim_pkg::DOT_MIN : cossim_pkg::DOT_MAX;
    end else begin
      dot_next = dot_wide[cossim_pkg::DOT_W-1:0];
    end
    norm_a_next = na_of ? cossim_pkg::NORM_MAX : na_wide[cossim_pkg::NORM_W-1:0];
    norm_b_next = nb_of ? cossim_pkg::NORM_MAX : nb_wide[cossim_pkg::NORM_W-1:0];
    sat_next    = saturated_flag | dot_of | na_of | nb_of;
  end

  // Hand finished sums to the queue on the last pair
  assign push             = advance & s1_last;
  assign push_data.dot    = dot_next;
  assign push_data.norm_a = norm_a_next;
  assign push_data.norm_b = norm_b_next;
  assign push_data.sat    = sat_next;

  // Advance the sums, clear them after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum        <= '0;
      norm_a_sum     <= '0;
      norm_b_sum     <= '0;
      saturated_flag <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        dot_sum        <= '0;
        norm_a_sum     <= '0;
        norm_b_sum     <= '0;
        saturated_flag <= 1'b0;
      end else begin
        dot_sum        <= dot_next;
        norm_a_sum     <= norm_a_next;
        norm_b_sum     <= norm_b_next;
        saturated_flag <= sat_next;
      end
    end
  end

endmodule

### src/cossim_fifo.sv
// Short queue of finished sums between the front and back ends.
module cossim_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cossim_pkg::sums_t      push_data,
  input  logic                   pop,
  output cossim_pkg::sums_t      pop_data,
  output cossim_pkg::fifo_stat_t stat
);

  cossim_pkg::sums_t                 entries [cossim_pkg::FIFO_DEPTH];
  logic [cossim_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [cossim_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [cossim_pkg::FIFO_CW-1:0]    count;

  assign stat.full  = count == cossim_pkg::FIFO_CW'(cossim_pkg::FIFO_DEPTH);
  assign stat.empty = count == '0;
  assign pop_data   = entries[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cossim_pkg::FIFO_AW'(cossim_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + cossim_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cossim_pkg::FIFO_AW'(cossim_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + cossim_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + cossim_pkg::FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - cossim_pkg::FIFO_CW'(1);
      end
    end
  end

endmodule

### src/cossim_divider.sv
// Back end: squares the dot, multiplies the norms, searches the Q1.15 cosine.
module cossim_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  cossim_pkg::fifo_stat_t             fifo_stat,
  output logic                               pop,
  input  cossim_pkg::sums_t                  pop_data,
  output logic signed [cossim_pkg::Q_W-1:0]  similarity,
  output logic                               zero_norm,
  output logic                               overflowed,
  output logic                               result_valid,
  input  logic                               result_stall
);

  cossim_pkg::back_state_t              state;
  cossim_pkg::back_state_t              state_next;
  logic                                 load_out;
  logic                                 mul_last;
  logic                                 test_ok;
  logic                                 search_done;
  logic                                 pop_zero;
  logic [cossim_pkg::MAG_W-1:0]         pop_mag;

  logic [cossim_pkg::MUL_CNT_W-1:0]     cnt;
  logic [cossim_pkg::MUL_W-1:0]         mcand_d;
  logic [cossim_pkg::MAG_W-1:0]         mplier_d;
  logic [cossim_pkg::MUL_W-1:0]         acc_d;
  logic [cossim_pkg::MUL_W-1:0]         mcand_n;
  logic [cossim_pkg::MAG_W-1:0]         mplier_n;
  logic [cossim_pkg::MUL_W-1:0]         acc_n;

  logic [cossim_pkg::BIT_W-1:0]         bitk;
  logic [cossim_pkg::SRCH_W-1:0]        s_acc;
  logic [cossim_pkg::SRCH_W-1:0]        t_acc;
  logic [cossim_pkg::SRCH_W-1:0]        x_reg;
  logic [cossim_pkg::SRCH_W-1:0]        s_cand;
  logic [cossim_pkg::SRCH_W-1:0]        r_val;
  logic [cossim_pkg::SRCH_W-1:0]        p_val;
  logic [cossim_pkg::SH_W-1:0]          t_shift;
  logic [cossim_pkg::SH_W-1:0]          p_shift;
  logic [cossim_pkg::Q_W-1:0]           q;
  logic [cossim_pkg::Q_W-1:0]           q_neg;
  logic [cossim_pkg::Q_W-1:0]           sim_val;
  logic                                 neg;
  logic                                 zero;
  logic                                 sat;

  // Classify the queued sums
  assign pop_zero = (pop_data.norm_a == '0) | (pop_data.norm_b == '0);
  assign pop_mag  = pop_data.dot[cossim_pkg::DOT_W-1] ?
                    cossim_pkg::MAG_W'(-pop_data.dot) : cossim_pkg::MAG_W'(pop_data.dot);

  // Search operands: R = dot^2 * 2^30, P = normA * normB
  assign r_val   = cossim_pkg::SRCH_W'(acc_d) << cossim_pkg::R_SHIFT;
  assign p_val   = cossim_pkg::SRCH_W'(acc_n);
  assign t_shift = cossim_pkg::SH_W'(bitk) + cossim_pkg::SH_W'(1);
  assign p_shift = {bitk, 1'b0};
  assign s_cand  = s_acc + x_reg;
  assign test_ok = s_cand <= r_val;

  assign mul_last    = cnt == cossim_pkg::MUL_CNT_W'(cossim_pkg::MAG_W - 1);
  assign search_done = (test_ok && bitk == cossim_pkg::BIT_W'(cossim_pkg::Q_W - 1)) ||
                       (bitk == '0);

  // Sign and clamp the magnitude
  assign q_neg   = ~q + cossim_pkg::Q_W'(1);
  assign sim_val = neg ? q_neg : (q[cossim_pkg::Q_W-1] ? cossim_pkg::SIM_MAX : q);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cossim_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      cossim_pkg::ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop        = 1'b1;
          state_next = pop_zero ? cossim_pkg::ST_OUT : cossim_pkg::ST_MUL;
        end
      end
      cossim_pkg::ST_MUL: begin
        if (mul_last) begin
          state_next = cossim_pkg::ST_PREP;
        end
      end
      cossim_pkg::ST_PREP: begin
        state_next = cossim_pkg::ST_TEST;
      end
      cossim_pkg::ST_TEST: begin
        state_next = search_done ? cossim_pkg::ST_OUT : cossim_pkg::ST_PREP;
      end
      cossim_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = cossim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cossim_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: load, shift-add multiply, then one quotient bit per PREP and TEST pass
  always_ff @(posedge clk) begin
    case (state)
      cossim_pkg::ST_IDLE: begin
        neg      <= pop_data.dot[cossim_pkg::DOT_W-1];
        zero     <= pop_zero;
        sat      <= pop_data.sat;
        mcand_d  <= cossim_pkg::MUL_W'(pop_mag);
        mplier_d <= pop_mag;
        acc_d    <= '0;
        mcand_n  <= cossim_pkg::MUL_W'(pop_data.norm_a);
        mplier_n <= cossim_pkg::MAG_W'(pop_data.norm_b);
        acc_n    <= '0;
        cnt      <= '0;
        bitk     <= cossim_pkg::BIT_W'(cossim_pkg::Q_W - 1);
        s_acc    <= '0;
        t_acc    <= '0;
        q        <= '0;
      end
      cossim_pkg::ST_MUL: begin
        acc_d    <= acc_d + (mplier_d[0] ? mcand_d : '0);
        mcand_d  <= mcand_d << 1;
        mplier_d <= mplier_d >> 1;
        acc_n    <= acc_n + (mplier_n[0] ? mcand_n : '0);
        mcand_n  <= mcand_n << 1;
        mplier_n <= mplier_n >> 1;
        cnt      <= cnt + cossim_pkg::MUL_CNT_W'(1);
      end
      cossim_pkg::ST_PREP: begin
        // Growth of q^2 * P when bit k is set: 2^(k+1) * q * P + 2^(2k) * P
        x_reg <= (t_acc << t_shift) + (p_val << p_shift);
      end
      cossim_pkg::ST_TEST: begin
        if (test_ok) begin
          s_acc   <= s_cand;
          t_acc   <= t_acc + (p_val << bitk);
          q[bitk] <= 1'b1;
        end
        bitk <= bitk - cossim_pkg::BIT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      similarity <= $signed(sim_val);
      zero_norm  <= zero;
      overflowed <= sat;
    end
  end

endmodule

### src/cosine_similarity.sv
// Top level of the streaming cosine similarity block.
// Usage:
//   Element channel: element_a, element_b, last_element with elem_valid and
//   elem_stall. A transaction completes on a clock edge with elem_valid high
//   and elem_stall low; one element pair per cycle is taken.
//   Result channel: similarity (signed Q1.15), zero_norm, overflowed with
//   result_valid and result_stall. One result follows each last_element.
//   After the last pair, the product stage pushes the sums into the queue; the
//   back end pops them, forms dot^2 and normA*normB by shift-add multiply,
//   searches up to 16 quotient bits and then loads the output register. A zero
//   norm skips the arithmetic and goes straight to the output register.
//   Throughput: one element pair per cycle while elem_stall is low; the back
//   end takes one vector pair at a time through the serial multiplier and bit search.
//   A two-entry queue holds finished sums so the next vector streams in
//   while the back end works.
//   Reset (rst, synchronous) clears the sums, the queue and result_valid.
//   When result_stall is high the result holds; the back end then finishes
//   the next vector and waits, the queue fills and elem_stall rises only on
//   a last pair that finds no queue space.
module cosine_similarity (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic signed [cossim_pkg::ELEM_BITS-1:0]  element_a,
  input  logic signed [cossim_pkg::ELEM_BITS-1:0]  element_b,
  input  logic                                     last_element,
  input  logic                                     elem_valid,
  output logic                                     elem_stall,
  output logic signed [cossim_pkg::Q_W-1:0]        similarity,
  output logic                                     zero_norm,
  output logic                                     overflowed,
  output logic                                     result_valid,
  input  logic                                     result_stall
);

  logic                   push;
  logic                   pop;
  cossim_pkg::sums_t      push_data;
  cossim_pkg::sums_t      pop_data;
  cossim_pkg::fifo_stat_t fifo_stat;

  // Accumulate element pairs
  cossim_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .element_a    (element_a),
    .element_b    (element_b),
    .last_element (last_element),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .push         (push),
    .push_data    (push_data),
    .fifo_stat    (fifo_stat)
  );

  // Queue finished sums
  cossim_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  // Compute and deliver the cosine
  cossim_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .fifo_stat    (fifo_stat),
    .pop          (pop),
    .pop_data     (pop_data),
    .similarity   (similarity),
    .zero_norm    (zero_norm),
    .overflowed   (overflowed),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

### src/cossim_checker.sv
// Port-level checks for the cosine similarity block, bound to its top level.
`include "cosine_similarity_defines.svh"

module cossim_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     last_element,
  input logic                                     elem_valid,
  input logic                                     elem_stall,
  input logic signed [cossim_pkg::Q_W-1:0]        similarity,
  input logic                                     zero_norm,
  input logic                                     overflowed,
  input logic                                     result_valid,
  input logic                                     result_stall
);

  logic       last_in;
  logic       res_out;
  logic [3:0] pending;

  assign last_in = elem_valid & ~elem_stall & last_element;
  assign res_out = result_valid & ~result_stall;

  // Track vectors closed but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(last_in) - 4'(res_out);
    end
  end

  `CS_ASSERT_IMPLY(a_zero_norm_zero, result_valid && zero_norm, similarity == 16'sd0, "zero norm with nonzero similarity")
  `CS_ASSERT_IMPLY(a_result_has_vector, result_valid, pending != 4'd0, "result without a closed vector")
  `CS_ASSERT_IMPLY(a_stall_has_vector, elem_stall, pending != 4'd0, "element stall with no vector in flight")
  `CS_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(similarity) && $stable(zero_norm) && $stable(overflowed), "stalled result changed")

endmodule

bind cosine_similarity cossim_checker u_cossim_checker (.*);

### bench/cosine_similarity_tb.sv
// Self-checking testbench for the streaming cosine similarity block.
`timescale 1ns / 100ps

module cosine_similarity_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_PAIRS   = 900;
  localparam int CALM_PAIRS     = 150;

  // Content shapes for random vector pairs
  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_ZERO_A,
    FILL_ZERO_B,
    FILL_ALIGNED,
    FILL_EXTREME
  } fill_t;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic signed [cossim_pkg::ELEM_BITS-1:0] element_a = '0;
  logic signed [cossim_pkg::ELEM_BITS-1:0] element_b = '0;
  logic                                    last_element = 1'b0;
  logic                                    elem_valid = 1'b0;
  logic                                    elem_stall;
  logic signed [cossim_pkg::Q_W-1:0]       similarity;
  logic                                    zero_norm;
  logic                                    overflowed;
  logic                                    result_valid;
  logic                                    result_stall = 1'b0;

  logic allow_idle = 1'b1;
  int   pairs_sent = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  cosine_similarity u_top (
    .clk          (clk),
    .rst          (rst),
    .element_a    (element_a),
    .element_b    (element_b),
    .last_element (last_element),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .similarity   (similarity),
    .zero_norm    (zero_norm),
    .overflowed   (overflowed),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // Track running sums and queue the cosine each finished vector pair must give
  class cosine_scoreboard;
    typedef struct {
      logic signed [cossim_pkg::Q_W-1:0] sim;
      logic                              zero;
      logic                              ovf;
    } cos_result_t;

    cos_result_t                         expected_q[$];
    logic signed [cossim_pkg::DOT_W-1:0] dot_acc;
    logic [cossim_pkg::NORM_W-1:0]       norm_a_acc;
    logic [cossim_pkg::NORM_W-1:0]       norm_b_acc;
    logic                                sat_seen;
    int                                  errors;

    function new();
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      dot_acc    = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
      sat_seen   = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Largest q in 0..32768 with q^2 * na * nb <= mag^2 * 2^30
    function longint cos_magnitude(longint mag, longint na, longint nb);
      bit [127:0] m128, na128, nb128, q128, rhs, lhs;
      longint     lo, hi, mid;
      m128  = mag;
      na128 = na;
      nb128 = nb;
      rhs   = (m128 * m128) << cossim_pkg::R_SHIFT;
      lo    = 0;
      hi    = 32768;
      while (lo < hi) begin
        mid  = (lo + hi + 1) / 2;
        q128 = mid;
        lhs  = q128 * q128 * na128 * nb128;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // Accumulate one element pair; on the last pair, queue the cosine
    task note_input(logic signed [cossim_pkg::ELEM_BITS-1:0] a,
                    logic signed [cossim_pkg::ELEM_BITS-1:0] b, logic last);
      longint      d, na, nb, q, s;
      cos_result_t r;
      d  = longint'(dot_acc) + longint'(a) * longint'(b);
      na = longint'(norm_a_acc) + longint'(a) * longint'(a);
      nb = longint'(norm_b_acc) + longint'(b) * longint'(b);
      if (d > longint'(cossim_pkg::DOT_MAX)) begin
        d = longint'(cossim_pkg::DOT_MAX);
        sat_seen = 1'b1;
      end
      if (d < longint'(cossim_pkg::DOT_MIN)) begin
        d = longint'(cossim_pkg::DOT_MIN);
        sat_seen = 1'b1;
      end
      if (na > longint'(cossim_pkg::NORM_MAX)) begin
        na = longint'(cossim_pkg::NORM_MAX);
        sat_seen = 1'b1;
      end
      if (nb > longint'(cossim_pkg::NORM_MAX)) begin
        nb = longint'(cossim_pkg::NORM_MAX);
        sat_seen = 1'b1;
      end
      dot_acc    = d[cossim_pkg::DOT_W-1:0];
      norm_a_acc = na[cossim_pkg::NORM_W-1:0];
      norm_b_acc = nb[cossim_pkg::NORM_W-1:0];
      if (!last) return;

      r.ovf  = sat_seen;
      r.zero = 1'b0;
      s      = 0;
      if (na == 0 || nb == 0) begin
        r.zero = 1'b1;
      end else begin
        q = cos_magnitude((d < 0) ? -d : d, na, nb);
        if (d < 0) s = -q;
        else s = (q > longint'(cossim_pkg::SIM_MAX)) ? longint'(cossim_pkg::SIM_MAX) : q;
      end
      r.sim = s[cossim_pkg::Q_W-1:0];
      expected_q.push_back(r);
      clear_sums();
    endtask

    // Compare one result transaction with the oldest expectation
    task check(logic signed [cossim_pkg::Q_W-1:0] sim, logic zero, logic ovf);
      cos_result_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("result sim=%0d zero=%0b ovf=%0b with nothing pending",
                         sim, zero, ovf));
        return;
      end
      r = expected_q.pop_front();
      if (sim !== r.sim)
        report($sformatf("similarity %0d, want %0d", sim, r.sim));
      if (zero !== r.zero)
        report($sformatf("zero_norm %0b, want %0b", zero, r.zero));
      if (ovf !== r.ovf)
        report($sformatf("overflowed %0b, want %0b", ovf, r.ovf));
    endtask
  endclass

  cosine_scoreboard sb = new();

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor both channels and watch for a stuck block
  always @(posedge clk) begin
    if (!rst) begin
      if (elem_valid && !elem_stall)
        sb.note_input(element_a, element_b, last_element);
      if (result_valid && !result_stall)
        sb.check(similarity, zero_norm, overflowed);
      if ((elem_valid && !elem_stall) || (result_valid && !result_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stall the result channel in bursts of random length
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 10);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Drive one element pair and hold it until the transaction completes
  task automatic send_pair(logic signed [cossim_pkg::ELEM_BITS-1:0] a,
                           logic signed [cossim_pkg::ELEM_BITS-1:0] b, logic last);
    @(negedge clk);
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      elem_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    element_a    <= a;
    element_b    <= b;
    last_element <= last;
    elem_valid   <= 1'b1;
    do @(posedge clk); while (elem_stall);
    pairs_sent++;
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic drain();
    @(negedge clk);
    elem_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [cossim_pkg::ELEM_BITS-1:0] extreme_elem();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Send one vector pair whose content follows the given shape
  task automatic send_vector(int len, fill_t fill);
    logic signed [cossim_pkg::ELEM_BITS-1:0] a, b;
    logic                                    flip;
    flip = 1'($urandom_range(0, 1));
    for (int k = 0; k < len; k++) begin
      a = cossim_pkg::ELEM_BITS'($urandom);
      b = cossim_pkg::ELEM_BITS'($urandom);
      case (fill)
        FILL_SMALL: begin
          a = cossim_pkg::ELEM_BITS'($urandom_range(0, 16) - 8);
          b = cossim_pkg::ELEM_BITS'($urandom_range(0, 16) - 8);
        end
        FILL_ZERO_A:  a = '0;
        FILL_ZERO_B:  b = '0;
        FILL_ALIGNED: b = flip ? -a : a;
        FILL_EXTREME: begin
          a = extreme_elem();
          b = extreme_elem();
        end
        default: ;
      endcase
      send_pair(a, b, k == len - 1);
    end
  endtask

  task automatic random_vectors(int n_pairs);
    int    target, len;
    fill_t fill;
    target = pairs_sent + n_pairs;
    while (pairs_sent < target) begin
      len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 48);
      fill = fill_t'($urandom_range(FILL_FULL, FILL_EXTREME));
      send_vector(len, fill);
    end
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single pairs at full scale: +1.0 saturates, -1.0 is exact
    send_pair(32767, 32767, 1'b1);
    send_pair(-32768, -32768, 1'b1);
    send_pair(-32768, 32767, 1'b1);
    send_pair(32767, -32768, 1'b1);
    send_pair(-1, 1, 1'b1);
    // Zero norm on A, on B and on both
    send_pair(0, 1234, 1'b1);
    send_pair(-5, 0, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(0, 0, 1'b0);
    send_pair(0, 7, 1'b1);
    // Orthogonal and mixed short vectors
    send_pair(1, 0, 1'b0);
    send_pair(0, 1, 1'b1);
    send_pair(3, 4, 1'b0);
    send_pair(4, -3, 1'b0);
    send_pair(-1, -1, 1'b1);
    send_pair(1, 1, 1'b0);
    send_pair(1, 1, 1'b0);
    send_pair(1, 2, 1'b1);
    send_pair(12345, -23456, 1'b0);
    send_pair(-32768, 32767, 1'b0);
    send_pair(0, 0, 1'b1);
    drain();

    // Random vectors with idling on both sides, then a calm stretch
    random_vectors(RANDOM_PAIRS - CALM_PAIRS);
    drain();
    allow_idle <= 1'b0;
    random_vectors(CALM_PAIRS);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
